/* rtl/fpzmp_pkg.sv */
// Shared types, constants and helper functions of the foot pressure lateral ZMP core.
// Used by the divider, the controller, the datapath and the top level.
package fpzmp_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);
    localparam int RD_W         = 16;
    localparam int OFF_W        = 15;
    localparam int Q_W          = 24;
    localparam int TOTAL_W      = Q_W + IDX_W;
    localparam int PROD_W       = Q_W + OFF_W;
    localparam int WSUM_W       = PROD_W + IDX_W - 1;
    localparam int DIVD_W       = WSUM_W;
    localparam int DIVS_W       = TOTAL_W;
    localparam int STEP_W       = $clog2(Q_W + 1);
    localparam int ZMP_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [RD_W-1:0]  MAX_RESET    = 16'd410;
    localparam logic [RD_W-1:0]  CAP_RESET    = 16'd20480;
    localparam logic [OFF_W-1:0] OUTER_RESET  = 15'd5243;
    localparam logic [OFF_W-1:0] INNER_RESET  = 15'd1966;
    localparam logic [Q_W-1:0]   Q_SAT        = {Q_W{1'b1}};
    localparam logic [Q_W-1:0]   ZMP_MAG_MAX  = 24'd32767;

    // Sensors that sit at the inner lateral offset; the rest use the outer one.
    localparam logic [SENSOR_COUNT-1:0] USE_INNER = 8'b0101_1010;

    typedef logic [SENSOR_COUNT-1:0][RD_W-1:0] reading_vec_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_CAP      = 2'd0,
        CFG_OUTER_OFFSET = 2'd1,
        CFG_INNER_OFFSET = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVW,
        ST_MUL,
        ST_ACC,
        ST_DIFF,
        ST_FSTART,
        ST_FDIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             load;
        logic             take_q;
        logic             mul;
        logic             acc;
        logic             diff;
        logic             fstart;
        logic             publish;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic sat;
        logic div_done;
        logic total_zero;
        logic out_busy;
    } dp_status_t;

    // Left-foot sensors come first and add to the positive side.
    function automatic logic is_left(input logic [IDX_W-1:0] idx);
        return ~idx[IDX_W-1];
    endfunction

endpackage

/* rtl/fpzmp_div.sv */
// Shared restoring divider, one quotient bit per cycle, for the ZMP core.
// Depends on fpzmp_pkg for operand widths.
module fpzmp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fpzmp_pkg::DIVD_W-1:0]  dividend,
    input  logic [fpzmp_pkg::DIVS_W-1:0]  divisor,
    output logic                          done,
    output logic [fpzmp_pkg::Q_W-1:0]     quotient
);
    import fpzmp_pkg::*;

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]    dq_reg, dq_next;
    logic [DIVS_W-1:0] dvs_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;
    logic              fits;

    // The caller guarantees that the quotient fits in Q_W bits, so the top
    // part of the dividend is already below the divisor.
    assign trial = {rem_reg, dq_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = DIVS_W'(dividend[DIVD_W-1 -: DIVD_W-Q_W]);
            dq_next   = dividend[Q_W-1:0];
            cnt_next  = STEP_W'(Q_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
            dq_next   = {dq_reg[Q_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

/* rtl/fpzmp_ctrl.sv */
// Controller state machine of the ZMP core: sequences sensors, divisions and output.
// Depends on fpzmp_pkg for the state, command and status types.
module fpzmp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  fpzmp_pkg::dp_status_t  status,
    output fpzmp_pkg::dp_cmd_t     cmd
);
    import fpzmp_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_LOAD;
            ST_LOAD:   state_next = status.sat ? ST_MUL : ST_DIVW;
            ST_DIVW:   if (status.div_done) state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = (idx_reg == IDX_W'(SENSOR_COUNT - 1)) ? ST_DIFF : ST_LOAD;
            ST_DIFF:   state_next = status.total_zero ? ST_FIN : ST_FSTART;
            ST_FSTART: state_next = ST_FDIV;
            ST_FDIV:   if (status.div_done) state_next = ST_FIN;
            ST_FIN:    if (!status.out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.idx = idx_reg;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_LOAD:   cmd.load    = 1'b1;
            ST_DIVW:   cmd.take_q  = status.div_done;
            ST_MUL:    cmd.mul     = 1'b1;
            ST_ACC:    cmd.acc     = 1'b1;
            ST_DIFF:   cmd.diff    = 1'b1;
            ST_FSTART: cmd.fstart  = 1'b1;
            ST_FDIV:   cmd.take_q  = 1'b0;
            ST_FIN:    cmd.publish = ~status.out_busy;
            default:   cmd.take_q  = 1'b0;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.capture) begin
            idx_next = '0;
        end else if (cmd.acc) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* rtl/fpzmp_dp.sv */
// Datapath of the ZMP core: sensor maxima, configuration, accumulators and output register.
// Depends on fpzmp_pkg and instantiates the shared divider fpzmp_div.
module fpzmp_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fpzmp_pkg::reading_vec_t             readings,
    input  logic                                cfg_write,
    input  logic [fpzmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpzmp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  fpzmp_pkg::dp_cmd_t                  cmd,
    output fpzmp_pkg::dp_status_t               status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fpzmp_pkg::ZMP_W-1:0]  m_zmp_lateral,
    output logic signed [fpzmp_pkg::ZMP_W-1:0]  m_previous_zmp_lateral,
    output logic                                m_pressure_present
);
    import fpzmp_pkg::*;

    logic [RD_W-1:0]    max_reg [SENSOR_COUNT];
    reading_vec_t       in_reg;
    logic [RD_W-1:0]    cap_reg;
    logic [OFF_W-1:0]   outer_reg;
    logic [OFF_W-1:0]   inner_reg;
    logic [Q_W-1:0]     q_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [WSUM_W-1:0]  wpos_reg;
    logic [WSUM_W-1:0]  wneg_reg;
    logic [WSUM_W-1:0]  mag_reg;
    logic               neg_reg;
    logic [ZMP_W-1:0]   zmp_out_reg;
    logic [ZMP_W-1:0]   prev_out_reg;
    logic [ZMP_W-1:0]   last_zmp_reg;
    logic               present_out_reg;
    logic               m_valid_reg, m_valid_next;

    logic [RD_W-1:0]    r_sel;
    logic [RD_W-1:0]    m_sel;
    logic [RD_W-1:0]    m_upd;
    logic               sat;
    logic [OFF_W-1:0]   off_sel;
    logic               div_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic               div_done;
    logic [Q_W-1:0]     div_q;
    logic [OFF_W-1:0]   zmp_mag;
    logic [ZMP_W-1:0]   zmp_val;
    logic               total_zero;

    assign r_sel   = in_reg[cmd.idx];
    assign m_sel   = max_reg[cmd.idx];
    assign m_upd   = (m_sel < r_sel && m_sel < cap_reg) ? r_sel : m_sel;
    // The quotient overflows 24 bits exactly when the reading reaches 256 times
    // the maximum, which also covers a zero maximum.
    assign sat     = {8'd0, r_sel[RD_W-1:8]} >= m_upd;
    assign off_sel = USE_INNER[cmd.idx] ? inner_reg : outer_reg;

    assign div_start    = (cmd.load && !sat) || cmd.fstart;
    assign div_dividend = cmd.fstart ? mag_reg
                                     : DIVD_W'({r_sel, 16'd0});
    assign div_divisor  = cmd.fstart ? total_reg : DIVS_W'(m_upd);

    fpzmp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign total_zero = total_reg == '0;
    assign zmp_mag    = (div_q > ZMP_MAG_MAX) ? OFF_W'(ZMP_MAG_MAX) : div_q[OFF_W-1:0];
    assign zmp_val    = total_zero ? '0
                      : (neg_reg ? ZMP_W'(-{1'b0, zmp_mag}) : {1'b0, zmp_mag});

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= CAP_RESET;
            outer_reg    <= OUTER_RESET;
            inner_reg    <= INNER_RESET;
            last_zmp_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                max_reg[i] <= MAX_RESET;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    CFG_MAX_CAP:      cap_reg   <= cfg_data;
                    CFG_OUTER_OFFSET: outer_reg <= cfg_data[OFF_W-1:0];
                    CFG_INNER_OFFSET: inner_reg <= cfg_data[OFF_W-1:0];
                    default:          cap_reg   <= cap_reg;
                endcase
            end
            if (cmd.load) begin
                max_reg[cmd.idx] <= m_upd;
            end
            if (cmd.publish) begin
                last_zmp_reg <= zmp_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg    <= readings;
            total_reg <= '0;
            wpos_reg  <= '0;
            wneg_reg  <= '0;
        end
        if (cmd.load && sat) begin
            q_reg <= Q_SAT;
        end else if (cmd.take_q) begin
            q_reg <= div_q;
        end
        if (cmd.mul) begin
            prod_reg  <= q_reg * off_sel;
            total_reg <= total_reg + TOTAL_W'(q_reg);
        end
        if (cmd.acc) begin
            if (is_left(cmd.idx)) begin
                wpos_reg <= wpos_reg + WSUM_W'(prod_reg);
            end else begin
                wneg_reg <= wneg_reg + WSUM_W'(prod_reg);
            end
        end
        if (cmd.diff) begin
            neg_reg <= wneg_reg > wpos_reg;
            mag_reg <= (wneg_reg > wpos_reg) ? wneg_reg - wpos_reg : wpos_reg - wneg_reg;
        end
        if (cmd.publish) begin
            zmp_out_reg     <= zmp_val;
            prev_out_reg    <= last_zmp_reg;
            present_out_reg <= ~total_zero;
        end
    end

    assign status.sat        = sat;
    assign status.div_done   = div_done;
    assign status.total_zero = total_zero;
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign m_valid                = m_valid_reg;
    assign m_zmp_lateral          = zmp_out_reg;
    assign m_previous_zmp_lateral = prev_out_reg;
    assign m_pressure_present     = present_out_reg;

endmodule

/* rtl/foot_pressure_lateral_zmp_core.sv */
// Top level of the foot pressure lateral ZMP core: ports, controller and datapath.
// Depends on fpzmp_pkg, fpzmp_ctrl and fpzmp_dp.
//
// The core takes eight Q4.12 foot force readings per transfer, normalizes each
// one by its sensor's running maximum and returns the lateral zero moment point
// in units of 2^-16 m, together with the previous point and a pressure flag.
// One item is worked on at a time. Each item needs up to nine divisions, all
// through one shared divider that yields one quotient bit per cycle. A sensor
// whose quotient saturates skips its division, and an item whose total
// pressure is zero skips the final one. A finished result waits in the output
// register while the next item is accepted. Configuration writes are always
// ready and are registered at once, so a write during an item also acts on it.
module foot_pressure_lateral_zmp_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [15:0]                         s_left_front_left,
    input  logic [15:0]                         s_left_front_right,
    input  logic [15:0]                         s_left_rear_left,
    input  logic [15:0]                         s_left_rear_right,
    input  logic [15:0]                         s_right_front_left,
    input  logic [15:0]                         s_right_front_right,
    input  logic [15:0]                         s_right_rear_left,
    input  logic [15:0]                         s_right_rear_right,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [15:0]                  m_zmp_lateral,
    output logic signed [15:0]                  m_previous_zmp_lateral,
    output logic                                m_pressure_present,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpzmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpzmp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fpzmp_pkg::*;

    reading_vec_t readings;
    dp_cmd_t      cmd;
    dp_status_t   status;

    assign readings[0] = s_left_front_left;
    assign readings[1] = s_left_front_right;
    assign readings[2] = s_left_rear_left;
    assign readings[3] = s_left_rear_right;
    assign readings[4] = s_right_front_left;
    assign readings[5] = s_right_front_right;
    assign readings[6] = s_right_rear_left;
    assign readings[7] = s_right_rear_right;

    assign cfg_ready = 1'b1;

    fpzmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fpzmp_dp u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .readings               (readings),
        .cfg_write              (cfg_valid && cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .cmd                    (cmd),
        .status                 (status),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_zmp_lateral          (m_zmp_lateral),
        .m_previous_zmp_lateral (m_previous_zmp_lateral),
        .m_pressure_present     (m_pressure_present)
    );

endmodule
